/* design/hover_limit_cycle_gain_learner_macros.svh */
// Assertion macros shared by the hover gain learner RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef HOVER_LIMIT_CYCLE_GAIN_LEARNER_MACROS_SVH
`define HOVER_LIMIT_CYCLE_GAIN_LEARNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HLCGL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hlcgl: same-cycle check failed");
// next-cycle implication
`define HLCGL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hlcgl: next-cycle check failed");
`else
`define HLCGL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLCGL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/hlcgl_pkg.sv */
// Shared widths, constants and types of the hover gain learner.
// No dependencies; imported by every module of the block.
package hlcgl_pkg;

    localparam int ErrW    = 15;
    localparam int DtW     = 16;
    localparam int GainW   = 16;
    localparam int PctW    = 7;
    localparam int CfgW    = 8;
    localparam int PeakW   = 14;
    localparam int TimerW  = 24;
    localparam int RecipW  = 32;
    localparam int ProdW   = DtW + RecipW;

    localparam logic [GainW-1:0] GainOne    = 16'd32768;
    localparam logic [GainW-1:0] GainFloor  = 16'd9830;
    localparam logic [14:0]      GainAttack = 15'd27853;

    localparam logic [PeakW-1:0] PeakMax  = 14'd16383;
    localparam logic [PeakW-1:0] CrossLsb = 14'd32;
    localparam logic [PeakW-1:0] AmplLsb  = 14'd128;

    localparam logic [TimerW-1:0] TimerMax  = 24'hFFFFFF;
    localparam logic [TimerW-1:0] HalfMinUs = 24'd60000;
    localparam logic [TimerW-1:0] HalfMaxUs = 24'd1200000;

    // release divide by 4e6 us: ceil(2^53 / 4e6), rounding bias 2e6 * recip
    localparam logic [RecipW-1:0] RelRecip = 32'd2251799814;
    localparam int                RelShift = 53;
    localparam logic [63:0]       RelBias  = 64'd4503599628000000;

    localparam logic [1:0] SgnNone = 2'd0;
    localparam logic [1:0] SgnPos  = 2'd1;
    localparam logic [1:0] SgnNeg  = 2'd2;

    typedef struct packed {
        logic step;
        logic clear;
    } t_det_cmd;

    typedef struct packed {
        logic [GainW-1:0] gain;
        logic             wb_valid;
        logic [PctW-1:0]  wb_pct;
    } t_gain_res;

endpackage

/* design/hlcgl_axis_det.sv */
// Zero-crossing detector for one attitude axis: sign, peak and flip timer.
// Depends on hlcgl_pkg.
module hlcgl_axis_det
    import hlcgl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_det_cmd               i_cmd,
    input  logic signed [ErrW-1:0] i_err,
    input  logic [DtW-1:0]         i_dt,
    output logic                   o_osc
);

    logic [1:0]        r_sign,  n_sign;
    logic [PeakW-1:0]  r_peak,  n_peak;
    logic [TimerW-1:0] r_tsf,   n_tsf;

    logic [ErrW-1:0]   w_abs;
    logic [PeakW-1:0]  w_mag;
    logic [PeakW-1:0]  w_peak;
    logic [TimerW:0]   w_tsum;
    logic [TimerW-1:0] w_t;
    logic [1:0]        w_nsgn;
    logic              w_neg;
    logic              w_opp;
    logic              w_flip;

    always_comb begin
        w_neg  = i_err[ErrW-1];
        // -16384 wraps to 16384 as unsigned, then saturates
        w_abs  = w_neg ? ErrW'(-i_err) : ErrW'(i_err);
        w_mag  = (w_abs > ErrW'(PeakMax)) ? PeakMax : w_abs[PeakW-1:0];
        w_tsum = {1'b0, r_tsf} + (TimerW+1)'(i_dt);
        w_t    = w_tsum[TimerW] ? TimerMax : w_tsum[TimerW-1:0];
        w_peak = (w_mag > r_peak) ? w_mag : r_peak;
        w_nsgn = w_neg ? SgnNeg : SgnPos;
        w_opp  = ((r_sign == SgnPos) && w_neg)
              || ((r_sign == SgnNeg) && !w_neg && (i_err != '0));
        w_flip = w_opp && (w_mag > CrossLsb);
        o_osc  = i_cmd.step && w_flip
              && (w_t > HalfMinUs) && (w_t < HalfMaxUs) && (w_peak > AmplLsb);
    end

    always_comb begin
        n_sign = r_sign;
        n_peak = r_peak;
        n_tsf  = r_tsf;
        if (i_cmd.clear) begin
            n_sign = SgnNone;
            n_peak = '0;
            n_tsf  = '0;
        end else if (i_cmd.step) begin
            if (r_sign == SgnNone) begin
                n_sign = w_nsgn;
                n_peak = w_peak;
                n_tsf  = w_t;
            end else if (w_flip) begin
                n_sign = w_nsgn;
                n_peak = w_mag;
                n_tsf  = '0;
            end else begin
                n_peak = w_peak;
                n_tsf  = w_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign <= SgnNone;
            r_peak <= '0;
            r_tsf  <= '0;
        end else begin
            r_sign <= n_sign;
            r_peak <= n_peak;
            r_tsf  <= n_tsf;
        end
    end

endmodule

/* design/hlcgl_gain_upd.sv */
// Gain state: load from config, attack on oscillation, release toward 1.0,
// percent writeback on leaving hang. Depends on hlcgl_pkg and the macro header.
`include "hover_limit_cycle_gain_learner_macros.svh"
module hlcgl_gain_upd
    import hlcgl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CfgW-1:0]  i_cfg_data,
    input  logic             i_step,
    input  logic             i_active,
    input  logic             i_osc,
    input  logic [ProdW-1:0] i_rel_prod,
    output t_gain_res        o_res
);

    // (p*32768 + 50) / 100 via ceil(2^29 / 100)
    localparam int            LoadNumW  = 22;
    localparam int            LoadShift = 29;
    localparam logic [22:0]   LoadRecip = 23'd5368710;
    localparam logic [LoadNumW-1:0] LoadBias = 22'd50;
    localparam logic [PctW-1:0] PctLo   = 7'd30;
    localparam logic [PctW-1:0] PctHi   = 7'd100;
    localparam logic [CfgW-1:0] PctInit = 8'd100;

    logic [GainW-1:0] r_load_gain, n_load_gain;
    logic [GainW-1:0] r_gain,      n_gain;
    logic             r_loaded,    n_loaded;
    logic             r_was_active, n_was_active;
    logic [CfgW-1:0]  r_stored,    n_stored;

    logic [PctW-1:0]      w_pclamp;
    logic [LoadNumW-1:0]  w_load_num;
    logic [44:0]          w_load_prod;
    logic [GainW-1:0]     w_gcur;
    logic [30:0]          w_att_prod;
    logic [GainW-1:0]     w_att;
    logic [14:0]          w_diff;
    logic [62:0]          w_rel_mul;
    logic [63:0]          w_rel_sum;
    logic [9:0]           w_inc;
    logic [GainW-1:0]     w_rel;
    logic [21:0]          w_pct_prod;
    logic [PctW-1:0]      w_q;
    logic [14:0]          w_r;
    logic                 w_rnd;
    logic [PctW-1:0]      w_lp;
    logic                 w_wb;

    function automatic logic [14:0] w_diff_calc(input logic [GainW-1:0] g);
        logic [GainW-1:0] d;
        d = GainOne - g;
        return d[14:0];
    endfunction

    always_comb begin
        if (i_cfg_data < CfgW'(PctLo)) begin
            w_pclamp = PctLo;
        end else if (i_cfg_data > CfgW'(PctHi)) begin
            w_pclamp = PctHi;
        end else begin
            w_pclamp = i_cfg_data[PctW-1:0];
        end
        w_load_num  = {w_pclamp, 15'd0} + LoadBias;
        w_load_prod = w_load_num * LoadRecip;

        w_gcur = r_loaded ? r_gain : r_load_gain;

        w_att_prod = w_gcur * GainAttack + 31'd16384;
        w_att      = w_att_prod[30:15];

        w_diff    = w_diff_calc(w_gcur);
        w_rel_mul = w_diff * i_rel_prod;
        w_rel_sum = 64'(w_rel_mul) + RelBias;
        w_inc     = w_rel_sum[RelShift +: 10];
        w_rel     = (w_gcur < GainOne) ? (w_gcur + GainW'(w_inc)) : w_gcur;

        // learned percent, round half to even
        w_pct_prod = w_gcur * 7'd100;
        w_q        = w_pct_prod[21:15];
        w_r        = w_pct_prod[14:0];
        w_rnd      = (w_r > 15'd16384) || ((w_r == 15'd16384) && w_q[0]);
        w_lp       = w_q + PctW'(w_rnd);
        w_wb       = i_step && !i_active && r_was_active
                  && ({1'b0, w_lp} != r_stored);
    end

    always_comb begin
        n_load_gain  = r_load_gain;
        n_gain       = r_gain;
        n_loaded     = r_loaded | i_step;
        n_was_active = i_step ? i_active : r_was_active;
        n_stored     = r_stored;
        if (i_cfg_we) begin
            n_load_gain = w_load_prod[LoadShift +: GainW];
            n_stored    = i_cfg_data;
        end else if (w_wb) begin
            n_stored    = {1'b0, w_lp};
        end
        if (i_step) begin
            if (!i_active) begin
                n_gain = w_gcur;
            end else if (i_osc) begin
                n_gain = (w_att < GainFloor) ? GainFloor : w_att;
            end else begin
                n_gain = w_rel;
            end
        end
        o_res.gain     = n_gain;
        o_res.wb_valid = w_wb;
        o_res.wb_pct   = w_wb ? w_lp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_gain  <= GainOne;
            r_gain       <= GainOne;
            r_loaded     <= 1'b0;
            r_was_active <= 1'b0;
            r_stored     <= PctInit;
        end else begin
            r_load_gain  <= n_load_gain;
            r_gain       <= n_gain;
            r_loaded     <= n_loaded;
            r_was_active <= n_was_active;
            r_stored     <= n_stored;
        end
    end

    `HLCGL_ASSERT_IMP(a_gain_range, i_clk, i_rst_n, r_loaded, (r_gain >= GainFloor) && (r_gain <= GainOne))
    `HLCGL_ASSERT_IMP(a_wb_needs_hang, i_clk, i_rst_n, !r_was_active, !o_res.wb_valid)
    `HLCGL_ASSERT_IMP(a_wb_pct_range, i_clk, i_rst_n, o_res.wb_valid, o_res.wb_pct <= PctHi)
    `HLCGL_ASSERT_NXT(a_step_active, i_clk, i_rst_n, i_step && i_active, r_was_active && r_loaded)

endmodule

/* design/hover_limit_cycle_gain_learner.sv */
// Top level of the hover limit-cycle gain learner: request registers,
// two axis detectors, gain update. Depends on hlcgl_pkg, hlcgl_axis_det, hlcgl_gain_upd.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    pitch, yaw error, dt_us, hang_active
//  result    out        o_valid / i_ready    gain_scale, writeback valid/percent
//  config    in         i_cfg_we             i_cfg_data (stored gain percent)
//
// One request per cycle sustained while results are drained; a taken request lands in
// the request register, then in the result register, which drives o_valid.
// The request register also forms dt_us times the release reciprocal, so the gain
// loop holds one multiply per path. Synchronous active-low reset clears the valid flags
// and the learner state, not the payload registers. A stalled result holds the pipe;
// the request register still takes a request when the result is drained in the same cycle.
module hover_limit_cycle_gain_learner
    import hlcgl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [ErrW-1:0] i_pitch_error,
    input  logic signed [ErrW-1:0] i_yaw_error,
    input  logic [DtW-1:0]         i_dt_us,
    input  logic                   i_hang_active,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [GainW-1:0]       o_gain_scale,
    output logic                   o_writeback_valid,
    output logic [PctW-1:0]        o_writeback_percent,
    input  logic                   i_cfg_we,
    input  logic [CfgW-1:0]        i_cfg_data
);

    logic                   r_in_vld;
    logic signed [ErrW-1:0] r_pitch;
    logic signed [ErrW-1:0] r_yaw;
    logic [DtW-1:0]         r_dt;
    logic                   r_act;
    logic [ProdW-1:0]       r_rel_prod;

    logic                   r_out_vld;
    logic [GainW-1:0]       r_gain_scale;
    logic                   r_wb_valid;
    logic [PctW-1:0]        r_wb_pct;

    logic      w_adv;
    logic      w_take;
    logic      w_osc_p;
    logic      w_osc_y;
    t_det_cmd  w_cmd;
    t_gain_res w_res;

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;
    assign w_take  = i_valid && o_ready;

    assign w_cmd.step  = w_adv && r_act;
    assign w_cmd.clear = w_adv && !r_act;

    hlcgl_axis_det u_det_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_err   (r_pitch),
        .i_dt    (r_dt),
        .o_osc   (w_osc_p)
    );

    hlcgl_axis_det u_det_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_err   (r_yaw),
        .i_dt    (r_dt),
        .o_osc   (w_osc_y)
    );

    hlcgl_gain_upd u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_adv),
        .i_active   (r_act),
        .i_osc      (w_osc_p || w_osc_y),
        .i_rel_prod (r_rel_prod),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pitch    <= i_pitch_error;
            r_yaw      <= i_yaw_error;
            r_dt       <= i_dt_us;
            r_act      <= i_hang_active;
            r_rel_prod <= i_dt_us * RelRecip;
        end
        if (w_adv) begin
            r_gain_scale <= w_res.gain;
            r_wb_valid   <= w_res.wb_valid;
            r_wb_pct     <= w_res.wb_pct;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_gain_scale        = r_gain_scale;
    assign o_writeback_valid   = r_wb_valid;
    assign o_writeback_percent = r_wb_pct;

endmodule

/* bench/hover_gain_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the hover gain learner: tracks register writes and accepted
// requests, predicts each result and compares it. Depends on hlcgl_pkg.
module hover_gain_checker
    import hlcgl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic signed [ErrW-1:0] i_pitch_error,
    input  logic signed [ErrW-1:0] i_yaw_error,
    input  logic [DtW-1:0]         i_dt_us,
    input  logic                   i_hang_active,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [GainW-1:0]       i_gain_scale,
    input  logic                   i_writeback_valid,
    input  logic [PctW-1:0]        i_writeback_percent,
    input  logic                   i_cfg_we,
    input  logic [CfgW-1:0]        i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int CfgReset = 100;
    localparam int PctMin   = 30;
    localparam int PctMax   = 100;
    localparam int TauUs    = 4_000_000;

    logic [CfgW-1:0]   cfg_pct;
    logic [CfgW-1:0]   saved_pct;
    logic [GainW-1:0]  gain;
    bit                have_gain;
    bit                in_hang;
    logic [1:0]        wave_sgn  [2];
    logic [PeakW-1:0]  wave_peak [2];
    logic [TimerW-1:0] wave_time [2];
    t_gain_res         pending_gains [$];
    int                fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_axes();
        for (int ax = 0; ax < 2; ax++) begin
            wave_sgn[ax]  = SgnNone;
            wave_peak[ax] = '0;
            wave_time[ax] = '0;
        end
    endfunction

    // zero-crossing detector of one axis; 1 when a half wave in the band closes
    function automatic bit axis_crossing(int ax, int err, int dt);
        int         mag;
        int         t;
        bit         osc;
        logic [1:0] nsgn;
        osc = 1'b0;
        mag = (err < 0) ? -err : err;
        if (mag > int'(PeakMax))
            mag = int'(PeakMax);
        t = int'(wave_time[ax]) + dt;
        wave_time[ax] = (t > int'(TimerMax)) ? TimerMax : t[TimerW-1:0];
        if (mag > int'(wave_peak[ax]))
            wave_peak[ax] = mag[PeakW-1:0];
        nsgn = (err >= 0) ? SgnPos : SgnNeg;
        if (wave_sgn[ax] == SgnNone) begin
            wave_sgn[ax] = nsgn;
        end else if (((wave_sgn[ax] == SgnPos && err < 0) || (wave_sgn[ax] == SgnNeg && err > 0))
                     && mag > int'(CrossLsb)) begin
            osc = wave_time[ax] > HalfMinUs && wave_time[ax] < HalfMaxUs
                  && wave_peak[ax] > AmplLsb;
            wave_sgn[ax]  = nsgn;
            wave_peak[ax] = mag[PeakW-1:0];
            wave_time[ax] = '0;
        end
        return osc;
    endfunction

    // gain * 100 / 2^15, round half to even
    function automatic int gain_to_pct(logic [GainW-1:0] g);
        int prod;
        int q;
        int r;
        prod = int'(g) * 100;
        q    = prod >>> 15;
        r    = prod & 32'h7FFF;
        if (r > 16384 || (r == 16384 && q[0]))
            q++;
        return q;
    endfunction

    function automatic t_gain_res step_learner(int pitch, int yaw, int dt, bit active);
        t_gain_res res;
        int        p;
        int        lp;
        int        g;
        longint    inc;
        bit        osc_p;
        bit        osc_y;
        res = '0;
        if (!have_gain) begin
            p = int'(cfg_pct);
            if (p < PctMin)
                p = PctMin;
            if (p > PctMax)
                p = PctMax;
            g         = (p * int'(GainOne) + 50) / 100;
            gain      = g[GainW-1:0];
            saved_pct = cfg_pct;
            have_gain = 1'b1;
        end
        if (!active) begin
            if (in_hang) begin
                lp = gain_to_pct(gain);
                if (lp != int'(saved_pct)) begin
                    saved_pct    = lp[CfgW-1:0];
                    res.wb_valid = 1'b1;
                    res.wb_pct   = lp[PctW-1:0];
                end
                in_hang = 1'b0;
            end
            clear_axes();
        end else begin
            in_hang = 1'b1;
            // both detectors advance every tick
            osc_p = axis_crossing(0, pitch, dt);
            osc_y = axis_crossing(1, yaw, dt);
            if (osc_p || osc_y) begin
                g    = (int'(gain) * int'(GainAttack) + 16384) >>> 15;
                gain = (g < int'(GainFloor)) ? GainFloor : g[GainW-1:0];
            end else if (gain < GainOne) begin
                inc  = (longint'(GainOne - gain) * dt + TauUs / 2) / TauUs;
                gain = gain + inc[GainW-1:0];
            end
        end
        res.gain = gain;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_gain_res want;
        if (!i_rst_n) begin
            cfg_pct   = CfgW'(CfgReset);
            saved_pct = CfgW'(CfgReset);
            gain      = GainOne;
            have_gain = 1'b0;
            in_hang   = 1'b0;
            clear_axes();
            pending_gains.delete();
        end else begin
            if (i_cfg_we) begin
                cfg_pct   = i_cfg_data;
                saved_pct = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                pending_gains.push_back(step_learner(int'(i_pitch_error), int'(i_yaw_error),
                                                     int'(i_dt_us), i_hang_active));
            if (i_res_valid && i_res_ready) begin
                if (pending_gains.size() == 0) begin
                    $display("%0t: unexpected result, gain_scale %0d", $time, i_gain_scale);
                    fails++;
                end else begin
                    want = pending_gains.pop_front();
                    if (i_gain_scale !== want.gain) begin
                        $display("%0t: gain_scale expected %0d, got %0d",
                                 $time, want.gain, i_gain_scale);
                        fails++;
                    end
                    if (i_writeback_valid !== want.wb_valid) begin
                        $display("%0t: writeback_valid expected %0d, got %0d",
                                 $time, want.wb_valid, i_writeback_valid);
                        fails++;
                    end
                    if (i_writeback_percent !== want.wb_pct) begin
                        $display("%0t: writeback_percent expected %0d, got %0d",
                                 $time, want.wb_pct, i_writeback_percent);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= pending_gains.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/tb_hover_limit_cycle_gain_learner.sv */
`timescale 1ns / 1ps
// Top of the hover gain learner bench: clock, reset, request and result traffic,
// register writes, watchdog and verdict. Depends on hlcgl_pkg and hover_gain_checker.
module tb_hover_limit_cycle_gain_learner;
    import hlcgl_pkg::*;

    localparam int HalfPeriod = 5;
    localparam int ResetLen   = 5;
    localparam int ItemTarget = 1050;
    localparam int HoldCycles = 300;
    localparam int IdleLimit  = 3000;
    localparam int SettleLen  = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic signed [ErrW-1:0] i_pitch_error;
    logic signed [ErrW-1:0] i_yaw_error;
    logic [DtW-1:0]         i_dt_us;
    logic                   i_hang_active;
    logic                   o_valid;
    logic                   i_ready;
    logic [GainW-1:0]       o_gain_scale;
    logic                   o_writeback_valid;
    logic [PctW-1:0]        o_writeback_percent;
    logic                   i_cfg_we;
    logic [CfgW-1:0]        i_cfg_data;

    int fail_count;
    int pending;
    int requests_sent = 0;
    int idle_cycles = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold = 1'b0;

    always #HalfPeriod i_clk = ~i_clk;

    hover_limit_cycle_gain_learner u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_pitch_error       (i_pitch_error),
        .i_yaw_error         (i_yaw_error),
        .i_dt_us             (i_dt_us),
        .i_hang_active       (i_hang_active),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_gain_scale        (o_gain_scale),
        .o_writeback_valid   (o_writeback_valid),
        .o_writeback_percent (o_writeback_percent),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data)
    );

    hover_gain_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_valid),
        .i_req_ready         (o_ready),
        .i_pitch_error       (i_pitch_error),
        .i_yaw_error         (i_yaw_error),
        .i_dt_us             (i_dt_us),
        .i_hang_active       (i_hang_active),
        .i_res_valid         (o_valid),
        .i_res_ready         (i_ready),
        .i_gain_scale        (o_gain_scale),
        .i_writeback_valid   (o_writeback_valid),
        .i_writeback_percent (o_writeback_percent),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // one request per call; valid stays high into the next call when no gap is drawn
    task automatic offer_tick(input int pitch, input int yaw, input int dt, input bit active);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pitch_error <= pitch[ErrW-1:0];
        i_yaw_error   <= yaw[ErrW-1:0];
        i_dt_us       <= dt[DtW-1:0];
        i_hang_active <= active;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_gain_pct(input int pct);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pct[CfgW-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int wave_amp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(129, 3000);
        if (r < 8)
            return $urandom_range(0, 200);
        return $urandom_range(3000, 11520);
    endfunction

    function automatic int wave_sample(int amp, bit neg);
        int v;
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(amp / 2, amp);
        return neg ? -v : v;
    endfunction

    // active stretch with square-ish oscillation on both axes, then leave the hang
    task automatic hang_session(input int ticks, input int dt_top);
        int left_p;
        int left_y;
        int amp_p;
        int amp_y;
        bit neg_p;
        bit neg_y;
        left_p = 0;
        left_y = 0;
        amp_p  = 0;
        amp_y  = 0;
        neg_p  = $urandom_range(0, 1);
        neg_y  = $urandom_range(0, 1);
        for (int k = 0; k < ticks; k++) begin
            if (left_p == 0) begin
                neg_p  = !neg_p;
                left_p = $urandom_range(1, 25);
                amp_p  = wave_amp();
            end
            if (left_y == 0) begin
                neg_y  = !neg_y;
                left_y = $urandom_range(1, 25);
                amp_y  = wave_amp();
            end
            left_p--;
            left_y--;
            offer_tick(wave_sample(amp_p, neg_p), wave_sample(amp_y, neg_y),
                       $urandom_range(0, dt_top), $urandom_range(0, 49) != 0);
        end
        repeat ($urandom_range(1, 2))
            offer_tick($urandom_range(0, 200), $urandom_range(0, 200),
                       $urandom_range(0, 65535), 1'b0);
    endtask

    task automatic noise_ticks(input int n);
        repeat (n)
            offer_tick($urandom(), $urandom(), $urandom_range(0, 65535), $urandom_range(0, 1));
    endtask

    // result side: per-result stall, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall   = rx_hold ? HoldCycles : (rx_idle ? $urandom_range(0, 19) : 0);
            rx_hold = 1'b0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int dt_top;
        int cfg_val;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pitch_error <= '0;
        i_yaw_error   <= '0;
        i_dt_us       <= '0;
        i_hang_active <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        repeat (ResetLen) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the gain loads once, from whatever sits in the register at the first request
        case ($urandom_range(0, 5))
            0: cfg_val = 0;
            1: cfg_val = 29;
            2: cfg_val = 30;
            3: cfg_val = 101;
            4: cfg_val = 255;
            default: cfg_val = $urandom_range(0, 255);
        endcase
        write_gain_pct(cfg_val);

        // directed: idle first tick, sign seeding, extremes, band edges, floor
        offer_tick(0, 0, 0, 1'b0);
        offer_tick(200, 0, 1000, 1'b1);
        offer_tick(11520, -16384, 30000, 1'b1);
        offer_tick(-11520, 16383, 65535, 1'b1);
        offer_tick(5000, 16383, 65535, 1'b1);
        offer_tick(40, -10, 65535, 1'b1);
        offer_tick(-20, 0, 0, 1'b1);
        offer_tick(-33, -11520, 60000, 1'b1);
        offer_tick(-16384, 11520, 0, 1'b1);
        offer_tick(0, 0, 65535, 1'b1);
        offer_tick(0, 0, 0, 1'b0);
        offer_tick(0, 0, 0, 1'b0);
        offer_tick(16383, -16384, 65535, 1'b1);
        offer_tick(-16384, 16383, 65535, 1'b1);
        for (int k = 0; k < 8; k++)
            offer_tick(k[0] ? -8000 : 8000, 0, 65535, 1'b1);
        offer_tick(0, 0, 0, 1'b0);

        phase = 0;
        while (requests_sent < ItemTarget) begin
            drain_results();
            case (phase % 6)
                0: cfg_val = 0;
                1: cfg_val = 255;
                2: cfg_val = 100;
                3: cfg_val = 30;
                default: cfg_val = $urandom_range(0, 255);
            endcase
            write_gain_pct(cfg_val);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            if (phase == 1) begin
                // receiver goes quiet while requests keep coming back to back
                tx_idle = 1'b0;
                rx_hold = 1'b1;
            end
            if (phase == 2) begin
                // long same-sign hang: flip timer saturates, later flip stays out of band
                for (int k = 0; k < 260; k++)
                    offer_tick($urandom_range(0, 31), $urandom_range(0, 500), 65535, 1'b1);
                offer_tick(-2000, -2000, 1000, 1'b1);
                offer_tick(0, 0, 0, 1'b0);
            end
            repeat (3) begin
                case ($urandom_range(0, 3))
                    0: dt_top = 2000;
                    1: dt_top = 10000;
                    2: dt_top = 40000;
                    default: dt_top = 65535;
                endcase
                hang_session($urandom_range(10, 60), dt_top);
            end
            noise_ticks($urandom_range(5, 15));
            phase++;
        end

        drain_results();
        repeat (SettleLen) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/hlcgl_pkg.sv
design/hlcgl_axis_det.sv
design/hlcgl_gain_upd.sv
design/hover_limit_cycle_gain_learner.sv
bench/hover_gain_checker.sv
bench/tb_hover_limit_cycle_gain_learner.sv
